// File: rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants of the soft timer bank
// field widths of the command and response transactions, command codes and
// sequencer states
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int CMD_W   = 4;
    localparam int SLOT_FW = 4;
    localparam int LIMIT_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 4'd0,
        CMD_SET_PARAM = 4'd1,
        CMD_START     = 4'd2,
        CMD_STOP      = 4'd3,
        CMD_PAUSE     = 4'd4,
        CMD_RESUME    = 4'd5,
        CMD_RESTART   = 4'd6,
        CMD_POLL      = 4'd7,
        CMD_ALLOC     = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_DRAIN,
        ST_POLL,
        ST_ALLOC,
        ST_RESP
    } state_t;

endpackage

// File: rtl/stb_cmd_if.sv
// ----------------------------------------------------------------------------
// stb_cmd_if: command channel of the soft timer bank
// valid/ready handshake carrying one command per transaction
// ----------------------------------------------------------------------------
interface stb_cmd_if
    import stb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_FW-1:0] slot;
    logic [LIMIT_W-1:0] limit_value;
    logic               repeat_mode;

    modport source (output valid, cmd, slot, limit_value, repeat_mode, input ready);
    modport sink   (input valid, cmd, slot, limit_value, repeat_mode, output ready);
endinterface

// File: rtl/stb_rsp_if.sv
// ----------------------------------------------------------------------------
// stb_rsp_if: response channel of the soft timer bank
// valid/ready handshake carrying one result per transaction
// ----------------------------------------------------------------------------
interface stb_rsp_if
    import stb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_FW-1:0] slot_out;

    modport source (output valid, hit, slot_out, input ready);
    modport sink   (input valid, hit, slot_out, output ready);
endinterface

// File: rtl/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/soft_timer_bank.sv
// ----------------------------------------------------------------------------
// soft_timer_bank: bank of one-shot / periodic software timers
// a small sequencer walks the slots through one shared compare and
// increment unit; limits and counts live in two rams
// ----------------------------------------------------------------------------
//
//  channel  role  payload                                 handshake
//  -------  ----  --------------------------------------  -----------
//  req      sink  cmd, slot, limit_value, repeat_mode     valid/ready
//  rsp      src   hit, slot_out                           valid/ready
//
// a tick reads the ram once per slot, pipelined against the count write-back;
//   an allocation examines one slot per cycle
// req.ready is high only while the sequencer idles; one command at a time,
//   the next one accepted in the cycle after the result is loaded at the earliest
// a result waits in the output register; a stalled rsp holds the sequencer
//   in its response state, never drops or repeats a transaction
// reset clears every flag and the valid bits of limit and count at once,
//   so no clearing pass over the rams is needed
// ----------------------------------------------------------------------------
module soft_timer_bank
    import stb_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    stb_cmd_if.sink  req,
    stb_rsp_if.source rsp
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W   = SCNT_W + SLOT_FW;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    // sequencer
    state_t state_reg, state_next;

    // latched command
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [SLOT_FW-1:0]     slot_reg, slot_next;
    logic [COUNT_WIDTH-1:0] lim_in_reg, lim_in_next;
    logic                   rep_reg, rep_next;

    // per-slot flags, and valid bits standing in for the ram reset value
    logic [SLOTS-1:0] alloc_reg, alloc_next;
    logic [SLOTS-1:0] en_reg, en_next;
    logic [SLOTS-1:0] per_reg, per_next;
    logic [SLOTS-1:0] limv_reg, limv_next;
    logic [SLOTS-1:0] cntv_reg, cntv_next;

    // walk index, pipeline flag, address of the last ram read
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] rd_idx_reg;

    // pending result and output register
    logic               res_hit_reg, res_hit_next;
    logic [SLOT_FW-1:0] res_slot_reg, res_slot_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic [SLOT_FW-1:0] out_slot_reg, out_slot_next;

    // ram ports
    logic [SLOT_W-1:0]      raddr;
    logic                   cnt_we;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic                   lim_we;
    logic [COUNT_WIDTH-1:0] cnt_rdata, lim_rdata;

    // shared compare and increment unit
    logic [COUNT_WIDTH-1:0] count_cur, lim_cur, count_inc;
    logic                   count_below;

    // decoded helpers
    logic [SLOT_W+SLOT_FW-1:0]  slot_ext;
    logic [SLOT_W-1:0]          slot_idx;
    logic                       in_range;
    logic [COUNT_WIDTH+LIMIT_W-1:0] lim_ext;
    logic [SLOT_W+SLOT_FW-1:0]  idx_ext;

    assign slot_ext = {{SLOT_W{1'b0}}, slot_reg};
    assign slot_idx = slot_ext[SLOT_W-1:0];
    assign in_range = (CMP_W'(slot_reg) < CMP_W'(SLOTS));
    assign lim_ext  = {{COUNT_WIDTH{1'b0}}, req.limit_value};
    assign idx_ext  = {{SLOT_FW{1'b0}}, idx_reg};

    // entries never written since reset read as zero
    assign count_cur   = cntv_reg[rd_idx_reg] ? cnt_rdata : '0;
    assign lim_cur     = limv_reg[rd_idx_reg] ? lim_rdata : '0;
    assign count_below = (count_cur < lim_cur);
    assign count_inc   = count_cur + COUNT_WIDTH'(1);

    // the walk reads the slot under the index, everything else the addressed slot
    assign raddr = (state_reg == ST_TICK) ? idx_reg : slot_idx;

    stb_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (SLOTS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (rd_idx_reg),
        .wdata (cnt_wdata),
        .raddr (raddr),
        .rdata (cnt_rdata)
    );

    stb_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (SLOTS)
    ) u_lim_ram (
        .clk   (clk),
        .we    (lim_we),
        .waddr (slot_idx),
        .wdata (lim_in_reg),
        .raddr (raddr),
        .rdata (lim_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (cmd_reg)
                    CMD_TICK:  state_next = ST_TICK;
                    CMD_POLL:  state_next = in_range ? ST_POLL : ST_RESP;
                    CMD_ALLOC: state_next = ST_ALLOC;
                    default:   state_next = ST_RESP;
                endcase
            end
            ST_TICK:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_RESP;
            ST_POLL:  state_next = ST_RESP;
            ST_ALLOC:
            begin
                if (!alloc_reg[idx_reg] || (idx_reg == LAST_IDX))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        lim_in_next    = lim_in_reg;
        rep_next       = rep_reg;
        alloc_next     = alloc_reg;
        en_next        = en_reg;
        per_next       = per_reg;
        limv_next      = limv_reg;
        cntv_next      = cntv_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_slot_next  = out_slot_reg;
        cnt_we         = 1'b0;
        cnt_wdata      = count_inc;
        lim_we         = 1'b0;

        // output register frees as soon as its transaction completes
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    slot_next   = req.slot;
                    lim_in_next = lim_ext[COUNT_WIDTH-1:0];
                    rep_next    = req.repeat_mode;
                end
            end
            ST_DECODE:
            begin
                res_hit_next  = 1'b0;
                res_slot_next = '0;
                idx_next      = '0;
                pend_next     = 1'b0;
                unique case (cmd_reg)
                    CMD_TICK, CMD_ALLOC:
                    begin
                    end
                    CMD_SET_PARAM:
                    begin
                        res_slot_next = slot_reg;
                        if (in_range)
                        begin
                            per_next[slot_idx]  = rep_reg;
                            cntv_next[slot_idx] = 1'b0;
                            limv_next[slot_idx] = 1'b1;
                            lim_we              = 1'b1;
                        end
                    end
                    CMD_START, CMD_RESUME:
                    begin
                        res_slot_next = slot_reg;
                        if (in_range)
                        begin
                            en_next[slot_idx] = 1'b1;
                        end
                    end
                    CMD_STOP:
                    begin
                        res_slot_next = slot_reg;
                        if (in_range)
                        begin
                            en_next[slot_idx]   = 1'b0;
                            cntv_next[slot_idx] = 1'b0;
                        end
                    end
                    CMD_PAUSE:
                    begin
                        res_slot_next = slot_reg;
                        if (in_range)
                        begin
                            en_next[slot_idx] = 1'b0;
                        end
                    end
                    CMD_RESTART:
                    begin
                        res_slot_next = slot_reg;
                        if (in_range)
                        begin
                            en_next[slot_idx]   = 1'b1;
                            cntv_next[slot_idx] = 1'b0;
                        end
                    end
                    CMD_POLL:
                    begin
                        res_slot_next = slot_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_TICK, ST_DRAIN:
            begin
                if (state_reg == ST_TICK)
                begin
                    idx_next  = idx_reg + SLOT_W'(1);
                    pend_next = 1'b1;
                end
                // slot read last cycle is updated while the next one is read
                if (pend_reg && alloc_reg[rd_idx_reg])
                begin
                    if (en_reg[rd_idx_reg])
                    begin
                        if (count_below)
                        begin
                            cnt_we                = 1'b1;
                            cntv_next[rd_idx_reg] = 1'b1;
                        end
                    end
                    else
                    begin
                        cntv_next[rd_idx_reg] = 1'b0;
                    end
                end
            end
            ST_POLL:
            begin
                if (en_reg[rd_idx_reg] && !count_below)
                begin
                    res_hit_next          = 1'b1;
                    cntv_next[rd_idx_reg] = 1'b0;
                    if (!per_reg[rd_idx_reg])
                    begin
                        en_next[rd_idx_reg] = 1'b0;
                    end
                end
            end
            ST_ALLOC:
            begin
                if (!alloc_reg[idx_reg])
                begin
                    alloc_next[idx_reg] = 1'b1;
                    res_hit_next        = 1'b1;
                    res_slot_next       = idx_ext[SLOT_FW-1:0];
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_slot_next  = res_slot_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alloc_reg     <= '0;
            en_reg        <= '0;
            per_reg       <= '0;
            limv_reg      <= '0;
            cntv_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            en_reg        <= en_next;
            per_reg       <= per_next;
            limv_reg      <= limv_next;
            cntv_reg      <= cntv_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        lim_in_reg   <= lim_in_next;
        rep_reg      <= rep_next;
        idx_reg      <= idx_next;
        rd_idx_reg   <= raddr;
        res_hit_reg  <= res_hit_next;
        res_slot_reg <= res_slot_next;
        out_hit_reg  <= out_hit_next;
        out_slot_reg <= out_slot_next;
    end

    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.hit      = out_hit_reg;
    assign rsp.slot_out = out_slot_reg;

    // counts are only written back by the tick walk
    a_cnt_we_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> ((state_reg == ST_TICK) || (state_reg == ST_DRAIN)))
        else $error("count write outside the tick walk");

    // an incremented count never passes its limit
    a_cnt_le_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (cnt_wdata <= lim_cur))
        else $error("count written above its limit");

    // an allocation marks the slot that it hands out
    a_alloc_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC) && !alloc_reg[idx_reg] |=> alloc_reg[$past(idx_reg)])
        else $error("allocated slot not marked");

    // a result only appears after the response state
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == ST_RESP))
        else $error("result loaded outside the response state");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the soft timer bank
// drives command transactions through a directed table and then random
// timer sequences, mirrors the slot state in a local model and compares
// every response transaction in order, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb;
    import stb_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int IDLE_PCT     = 16;
    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 40;

    // receiver hold-off and the quiet windows with no idling
    localparam int HOLD_AT      = 2000;
    localparam int HOLD_LEN     = 400;
    localparam int RX_QUIET_LO  = 6000;
    localparam int RX_QUIET_HI  = 9000;
    localparam int TX_QUIET_LO  = 400;
    localparam int TX_QUIET_HI  = 550;

    // opcode outside the defined set, must leave the bank untouched
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 4'hF;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_FW-1:0] slot;
        logic [LIMIT_W-1:0] limit_value;
        logic               repeat_mode;
    } timer_cmd_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_FW-1:0] slot_out;
    } timer_result_t;

    // typed = 1: the response is written into the row, else taken from the model
    typedef struct packed {
        timer_cmd_t    c;
        logic          typed;
        timer_result_t r;
    } dir_row_t;

    localparam int NUM_ROWS = 25;

    dir_row_t directed_rows [NUM_ROWS] = '{
        // straight after reset: nothing enabled, nothing allocated
        '{'{CMD_POLL,      4'd0,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd0}},
        '{'{CMD_TICK,      4'd5,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd0}},
        // allocation hands out the lowest free slots
        '{'{CMD_ALLOC,     4'd9,  32'd0,          1'b0}, 1'b1, '{1'b1, 4'd0}},
        '{'{CMD_ALLOC,     4'd3,  32'd0,          1'b0}, 1'b1, '{1'b1, 4'd1}},
        // one-shot with limit one: expires once, then disabled
        '{'{CMD_SET_PARAM, 4'd0,  32'd1,          1'b0}, 1'b1, '{1'b0, 4'd0}},
        '{'{CMD_START,     4'd0,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd0}},
        '{'{CMD_POLL,      4'd0,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd0}},
        '{'{CMD_TICK,      4'd0,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd0}},
        '{'{CMD_TICK,      4'd0,  32'd0,          1'b0}, 1'b0, '{1'b0, 4'd0}},
        '{'{CMD_POLL,      4'd0,  32'd0,          1'b0}, 1'b1, '{1'b1, 4'd0}},
        '{'{CMD_POLL,      4'd0,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd0}},
        // periodic with limit zero: every poll hits
        '{'{CMD_SET_PARAM, 4'd1,  32'd0,          1'b1}, 1'b1, '{1'b0, 4'd1}},
        '{'{CMD_RESTART,   4'd1,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd1}},
        '{'{CMD_POLL,      4'd1,  32'd0,          1'b0}, 1'b1, '{1'b1, 4'd1}},
        '{'{CMD_POLL,      4'd1,  32'd0,          1'b0}, 1'b1, '{1'b1, 4'd1}},
        // unallocated top slot with the largest limit: ticks leave it alone
        '{'{CMD_SET_PARAM, 4'd15, 32'hFFFF_FFFF,  1'b1}, 1'b1, '{1'b0, 4'd15}},
        '{'{CMD_START,     4'd15, 32'd0,          1'b0}, 1'b1, '{1'b0, 4'd15}},
        '{'{CMD_TICK,      4'd0,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd0}},
        '{'{CMD_POLL,      4'd15, 32'd0,          1'b0}, 1'b1, '{1'b0, 4'd15}},
        // pause, tick clears the count, resume
        '{'{CMD_PAUSE,     4'd1,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd1}},
        '{'{CMD_TICK,      4'd0,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd0}},
        '{'{CMD_RESUME,    4'd1,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd1}},
        '{'{CMD_POLL,      4'd1,  32'd0,          1'b0}, 1'b0, '{1'b0, 4'd0}},
        '{'{CMD_STOP,      4'd1,  32'd0,          1'b0}, 1'b1, '{1'b0, 4'd1}},
        // unknown opcode: zero response whatever the payload
        '{'{CMD_UNKNOWN,   4'd7,  32'h5A5A_A5A5,  1'b1}, 1'b1, '{1'b0, 4'd0}}
    };

    logic clk;
    logic rst_n;

    stb_cmd_if req_if ();
    stb_rsp_if rsp_if ();

    soft_timer_bank #(
        .SLOTS       (NUM_SLOTS),
        .COUNT_WIDTH (LIMIT_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // local copy of the timer bank
    bit                 slot_alloc [NUM_SLOTS];
    bit                 slot_en    [NUM_SLOTS];
    bit                 slot_per   [NUM_SLOTS];
    logic [LIMIT_W-1:0] slot_limit [NUM_SLOTS];
    logic [LIMIT_W-1:0] slot_count [NUM_SLOTS];

    timer_result_t expected_rsps [$];
    timer_cmd_t    pending_cmds  [$];
    int unsigned   mismatch_count;
    bit            tx_quiet;

    // ------------------------------------------------------------------------
    // clock, and a hard stop if the bench ever hangs
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // timer bank model: applies one command, returns its response
    // ------------------------------------------------------------------------
    function automatic timer_result_t timer_apply(input timer_cmd_t c);
        timer_result_t r;
        bit            found;
        r.hit      = 1'b0;
        r.slot_out = '0;
        found      = 1'b0;
        // the slot field cannot address beyond the bank at sixteen slots
        case (c.cmd)
            CMD_TICK:
            begin
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    if (slot_alloc[k])
                    begin
                        if (!slot_en[k])
                            slot_count[k] = '0;
                        else if (slot_count[k] < slot_limit[k])
                            slot_count[k] = slot_count[k] + 1'b1;
                    end
                end
            end
            CMD_SET_PARAM:
            begin
                r.slot_out          = c.slot;
                slot_per[c.slot]    = c.repeat_mode;
                slot_count[c.slot]  = '0;
                slot_limit[c.slot]  = c.limit_value;
            end
            CMD_START, CMD_RESUME:
            begin
                r.slot_out       = c.slot;
                slot_en[c.slot]  = 1'b1;
            end
            CMD_STOP:
            begin
                r.slot_out          = c.slot;
                slot_count[c.slot]  = '0;
                slot_en[c.slot]     = 1'b0;
            end
            CMD_PAUSE:
            begin
                r.slot_out       = c.slot;
                slot_en[c.slot]  = 1'b0;
            end
            CMD_RESTART:
            begin
                r.slot_out          = c.slot;
                slot_count[c.slot]  = '0;
                slot_en[c.slot]     = 1'b1;
            end
            CMD_POLL:
            begin
                r.slot_out = c.slot;
                if (slot_en[c.slot] && slot_count[c.slot] >= slot_limit[c.slot])
                begin
                    // a one-shot timer stops after its expiry is seen
                    if (!slot_per[c.slot])
                        slot_en[c.slot] = 1'b0;
                    slot_count[c.slot] = '0;
                    r.hit = 1'b1;
                end
            end
            CMD_ALLOC:
            begin
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    if (!found && !slot_alloc[k])
                    begin
                        slot_alloc[k] = 1'b1;
                        r.hit         = 1'b1;
                        r.slot_out    = k[SLOT_FW-1:0];
                        found         = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic timer_cmd_t mk_cmd(input logic [CMD_W-1:0] cmd,
                                          input logic [SLOT_FW-1:0] slot,
                                          input logic [LIMIT_W-1:0] lim,
                                          input logic rep);
        timer_cmd_t c;
        c.cmd         = cmd;
        c.slot        = slot;
        c.limit_value = lim;
        c.repeat_mode = rep;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // random stimulus: mostly complete timer sequences, some noise
    // ------------------------------------------------------------------------
    task automatic build_burst();
        logic [SLOT_FW-1:0] s;
        logic [LIMIT_W-1:0] lim;
        int                 sel;
        int                 n_ticks;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            // favour the low slots, which get allocated first
            s = ($urandom_range(0, 3) == 0) ? SLOT_FW'($urandom_range(0, 15))
                                            : SLOT_FW'($urandom_range(0, 5));
            sel = $urandom_range(0, 19);
            if (sel == 0)
                lim = 32'hFFFF_FFFF;
            else if (sel == 1)
                lim = $urandom;
            else
                lim = $urandom_range(0, 4);
            if ($urandom_range(0, 5) == 0)
                pending_cmds.push_back(mk_cmd(CMD_ALLOC, SLOT_FW'($urandom), $urandom,
                                              1'($urandom)));
            if ($urandom_range(0, 7) != 0)
                pending_cmds.push_back(mk_cmd(CMD_SET_PARAM, s, lim,
                                              1'($urandom_range(0, 1))));
            pending_cmds.push_back(mk_cmd($urandom_range(0, 1) ? CMD_START : CMD_RESTART,
                                          s, $urandom, 1'($urandom)));
            n_ticks = $urandom_range(0, 6);
            for (int k = 0; k < n_ticks; k++)
            begin
                pending_cmds.push_back(mk_cmd(CMD_TICK, SLOT_FW'($urandom), $urandom,
                                              1'($urandom)));
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    pending_cmds.push_back(mk_cmd(CMD_POLL, SLOT_FW'($urandom), $urandom,
                                                  1'($urandom)));
                else if (sel == 1)
                    pending_cmds.push_back(mk_cmd(CMD_PAUSE, s, $urandom, 1'($urandom)));
                else if (sel == 2)
                    pending_cmds.push_back(mk_cmd(CMD_RESUME, s, $urandom, 1'($urandom)));
            end
            pending_cmds.push_back(mk_cmd(CMD_POLL, s, $urandom, 1'($urandom)));
            if ($urandom_range(0, 2) == 0)
                pending_cmds.push_back(mk_cmd(CMD_POLL, s, $urandom, 1'($urandom)));
            if ($urandom_range(0, 4) == 0)
                pending_cmds.push_back(mk_cmd(CMD_STOP, s, $urandom, 1'($urandom)));
        end
        else
        begin
            // noise over the whole opcode space, unknown codes included
            n_ticks = $urandom_range(1, 4);
            for (int k = 0; k < n_ticks; k++)
                pending_cmds.push_back(mk_cmd(CMD_W'($urandom_range(0, 15)),
                                              SLOT_FW'($urandom), $urandom,
                                              1'($urandom_range(0, 1))));
        end
    endtask

    // ------------------------------------------------------------------------
    // command side: one transaction per call, random gaps before it
    // ------------------------------------------------------------------------
    task automatic send_cmd(input timer_cmd_t c, input logic typed,
                            input timer_result_t typed_rsp);
        timer_result_t model_rsp;
        if (!tx_quiet)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                req_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_if.valid       <= 1'b1;
        req_if.cmd         <= c.cmd;
        req_if.slot        <= c.slot;
        req_if.limit_value <= c.limit_value;
        req_if.repeat_mode <= c.repeat_mode;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        // accepted at this edge: the model always advances, a typed row
        // overrides what is expected
        model_rsp = timer_apply(c);
        expected_rsps.push_back(typed ? typed_rsp : model_rsp);
    endtask

    initial
    begin
        int            n_sent;
        timer_cmd_t    c;
        timer_result_t none;
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.cmd         <= '0;
        req_if.slot        <= '0;
        req_if.limit_value <= '0;
        req_if.repeat_mode <= 1'b0;
        tx_quiet       = 1'b0;
        mismatch_count = 0;
        none           = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            slot_alloc[k] = 1'b0;
            slot_en[k]    = 1'b0;
            slot_per[k]   = 1'b0;
            slot_limit[k] = '0;
            slot_count[k] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_ROWS; i++)
            send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].r);

        // random sequences, with one stretch of back-to-back commands
        n_sent = 0;
        while (n_sent < RANDOM_ITEMS)
        begin
            if (pending_cmds.size() == 0)
                build_burst();
            c = pending_cmds.pop_front();
            tx_quiet = (n_sent >= TX_QUIET_LO && n_sent < TX_QUIET_HI);
            send_cmd(c, 1'b0, none);
            n_sent++;
        end
        req_if.valid <= 1'b0;

        // wait for the last responses, then let the sequencer settle
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // response side: compare each transaction with the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_rsp(input logic hit, input logic [SLOT_FW-1:0] slot_out);
        timer_result_t want;
        if (expected_rsps.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected response: hit=%b slot_out=%0d", hit, slot_out);
        end
        else
        begin
            want = expected_rsps.pop_front();
            if (hit !== want.hit || slot_out !== want.slot_out)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"response mismatch: expected hit=%b slot_out=%0d,",
                              " got hit=%b slot_out=%0d"},
                             want.hit, want.slot_out, hit, slot_out);
            end
        end
    endtask

    // ready: random stalls, a long hold-off so the bank backs up onto the
    // command channel, and a window with no stalls at all
    initial
    begin
        int unsigned rx_cycle;
        rsp_if.ready <= 1'b0;
        rx_cycle = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rsp_if.valid && rsp_if.ready)
                check_rsp(rsp_if.hit, rsp_if.slot_out);
            if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN)
                rsp_if.ready <= 1'b0;
            else if (rx_cycle >= RX_QUIET_LO && rx_cycle < RX_QUIET_HI)
                rsp_if.ready <= 1'b1;
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

endmodule

// File: filelist.f
rtl/stb_pkg.sv
rtl/stb_cmd_if.sv
rtl/stb_rsp_if.sv
rtl/stb_ram.sv
rtl/soft_timer_bank.sv
tb/tb.sv
